// File: src/aes_pkg.sv
// AES-128 package: types, constants, S-box and GF(2^8) helper functions.
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

  localparam int BlockWidth = 128;
  localparam int HalfWidth  = 64;
  localparam int NumRounds  = 10;
  localparam int NumRoundKeys = NumRounds + 1;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } command_t;

  typedef enum logic {
    REG_KEY_UPPER = 1'b0,
    REG_KEY_LOWER = 1'b1
  } reg_index_t;

  typedef logic [BlockWidth-1:0] block_t;

  // Multiply by x in GF(2^8), reducing by the AES polynomial.
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] t;
    p = 8'h00;
    t = a;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) p = p ^ t;
      t = xtime(t);
    end
    gf_mul = p;
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] SBOX_REV [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Round constants for key expansion steps 1..10 (index 0 unused).
  localparam logic [7:0] RCON [NumRoundKeys] = '{
    8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte i of the block sits at bits [127-8i -: 8].
  function automatic logic [7:0] get_byte(input block_t s, input int i);
    get_byte = s[BlockWidth-1-8*i -: 8];
  endfunction

  function automatic block_t sub_bytes(input block_t s, input logic inv);
    block_t t;
    for (int i = 0; i < 16; i++) begin
      t[BlockWidth-1-8*i -: 8] = inv ? SBOX_REV[get_byte(s, i)] : SBOX[get_byte(s, i)];
    end
    sub_bytes = t;
  endfunction

  function automatic block_t shift_rows(input block_t s, input logic inv);
    block_t t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv) t[BlockWidth-1-8*(r+4*((c+r)%4)) -: 8] = get_byte(s, r + 4*c);
        else t[BlockWidth-1-8*(r+4*c) -: 8] = get_byte(s, r + 4*((c+r)%4));
      end
    end
    shift_rows = t;
  endfunction

  function automatic block_t mix_columns(input block_t s, input logic inv);
    block_t t;
    logic [7:0] m [4];
    logic [7:0] acc;
    if (inv) begin
      m[0] = 8'h0e; m[1] = 8'h0b; m[2] = 8'h0d; m[3] = 8'h09;
    end else begin
      m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) begin
          acc = acc ^ gf_mul(m[(k-r+4)%4], get_byte(s, k + 4*c));
        end
        t[BlockWidth-1-8*(r+4*c) -: 8] = acc;
      end
    end
    mix_columns = t;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // One key-expansion step: round key k-1 to round key k.
  function automatic block_t next_round_key(input block_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t  = sub_word({w3[23:0], w3[31:24]}) ^ {rc, 24'h000000};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_round_key = {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

// File: src/aes_stream_if.sv
// Valid/ready stream interface carrying one payload struct.
`timescale 1ns / 1ps
`default_nettype none
interface aes_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/aes_key_sched.sv
// Round key expansion: one round key per cycle into a register file.
`timescale 1ns / 1ps
`default_nettype none
module aes_key_sched (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   restart,
  input  wire aes_pkg::block_t        cipher_key,
  output logic                        ready,
  output aes_pkg::block_t             round_keys [aes_pkg::NumRoundKeys]
);
  import aes_pkg::*;

  localparam int StepWidth = $clog2(NumRoundKeys + 1);

  logic [StepWidth-1:0] step;
  logic                 busy;

  // Each round key is written by its own step; key 0 is the cipher key.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      step <= StepWidth'(1);
    end else if (restart) begin
      busy <= 1'b1;
      step <= StepWidth'(1);
    end else if (busy) begin
      if (step == StepWidth'(NumRoundKeys - 1)) busy <= 1'b0;
      step <= step + StepWidth'(1);
    end
  end

  // Reset loads the all-zero key.
  always_ff @(posedge clk) begin
    if (rst) begin
      round_keys[0] <= '0;
    end else if (restart) begin
      round_keys[0] <= cipher_key;
    end
    for (int k = 1; k < NumRoundKeys; k++) begin
      if (busy && !restart && !rst && step == StepWidth'(k)) begin
        round_keys[k] <= next_round_key(round_keys[k-1], RCON[k]);
      end
    end
  end

  assign ready = !busy && !restart;
endmodule
`default_nettype wire

// File: src/aes_round_stage.sv
// One registered cipher round, forward or inverse, with stall control.
`timescale 1ns / 1ps
`default_nettype none
module aes_round_stage #(
  parameter int RoundIdx = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic              in_valid,
  input  wire logic              in_inv,
  input  wire aes_pkg::block_t   in_state,
  input  wire aes_pkg::block_t   enc_key,
  input  wire aes_pkg::block_t   dec_key,
  output logic                   out_valid,
  output logic                   out_inv,
  output aes_pkg::block_t        out_state
);
  import aes_pkg::*;

  block_t state_next;
  block_t t;

  // Forward: sub, shift, mix (except last), add key.
  // Inverse: inv shift, inv sub, add key, inv mix (except last).
  always_comb begin
    if (!in_inv) begin
      t = shift_rows(sub_bytes(in_state, 1'b0), 1'b0);
      if (RoundIdx != NumRounds) t = mix_columns(t, 1'b0);
      state_next = t ^ enc_key;
    end else begin
      t = sub_bytes(shift_rows(in_state, 1'b1), 1'b1) ^ dec_key;
      if (RoundIdx != NumRounds) t = mix_columns(t, 1'b1);
      state_next = t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_inv   <= in_inv;
      out_state <= state_next;
    end
  end
endmodule
`default_nettype wire

// File: src/aes128_block_cipher.sv
// Top level of the pipelined AES-128 block cipher.
`timescale 1ns / 1ps
`default_nettype none
// AES-128 (FIPS-197) encrypt/decrypt engine, one 128-bit block per transfer.
// The datapath is a pipeline of eleven register stages: an input stage that
// applies the initial round key, then one stage per round. A new block can be
// taken every cycle while the output does not stall and the key schedule is
// ready. A block is offered at the output once it has passed the input stage
// and every round stage. The whole pipeline advances together, so a stall at
// the output holds every stage with nothing lost.
// Writing key_upper (index 0) or key_lower (index 1) restarts key expansion,
// which computes one round key per cycle; no input transfer is accepted in the
// write cycle or until expansion finishes. The same happens after reset, with
// the all-zero key. Stages read the round keys live, so write keys only while
// the pipeline is empty.
module aes128_block_cipher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  aes_stream_if.sink       in_ch,
  aes_stream_if.source     out_ch
);
  import aes_pkg::*;

  localparam int NumStages = NumRounds;

  logic [HalfWidth-1:0] key_upper;
  logic [HalfWidth-1:0] key_lower;
  logic                 key_write;
  logic                 sched_ready;
  block_t               round_keys [NumRoundKeys];

  logic                 advance;
  logic                 valid_pipe [NumStages+1];
  logic                 inv_pipe   [NumStages+1];
  block_t               state_pipe [NumStages+1];
  block_t               in_block;
  logic                 in_inv;
  logic                 entry_valid;
  logic                 entry_inv;
  block_t               entry_state;

  // Hold the key registers; any key write restarts the schedule.
  assign key_write = cfg_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0;
      key_lower <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_UPPER: key_upper <= cfg_data;
        REG_KEY_LOWER: key_lower <= cfg_data;
        default: ;
      endcase
    end
  end

  aes_key_sched u_key_sched (
    .clk        (clk),
    .rst        (rst),
    .restart    (key_write),
    .cipher_key ((cfg_write && cfg_index == REG_KEY_UPPER) ? {cfg_data, key_lower} :
                 (cfg_write && cfg_index == REG_KEY_LOWER) ? {key_upper, cfg_data} :
                 {key_upper, key_lower}),
    .ready      (sched_ready),
    .round_keys (round_keys)
  );

  // Advance the whole pipeline unless the output holds a result not yet taken.
  assign advance     = !valid_pipe[NumStages] || out_ch.ready;
  assign in_ch.ready = advance && sched_ready;

  assign in_block = {in_ch.data.block_upper, in_ch.data.block_lower};
  assign in_inv   = in_ch.data.command;

  // Input stage: initial round key (key 0 forward, key 10 inverse).
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (advance) begin
      entry_valid <= in_ch.valid && sched_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      entry_inv   <= in_inv;
      entry_state <= in_block ^ (in_inv ? round_keys[NumRounds] : round_keys[0]);
    end
  end

  assign valid_pipe[0] = entry_valid;
  assign inv_pipe[0]   = entry_inv;
  assign state_pipe[0] = entry_state;

  for (genvar g = 1; g <= NumStages; g++) begin : g_round
    aes_round_stage #(
      .RoundIdx (g)
    ) u_round (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_valid  (valid_pipe[g-1]),
      .in_inv    (inv_pipe[g-1]),
      .in_state  (state_pipe[g-1]),
      .enc_key   (round_keys[g]),
      .dec_key   (round_keys[NumRounds-g]),
      .out_valid (valid_pipe[g]),
      .out_inv   (inv_pipe[g]),
      .out_state (state_pipe[g])
    );
  end

  assign out_ch.valid              = valid_pipe[NumStages];
  assign out_ch.data.result_upper  = state_pipe[NumStages][BlockWidth-1:HalfWidth];
  assign out_ch.data.result_lower  = state_pipe[NumStages][HalfWidth-1:0];
endmodule
`default_nettype wire
